// ===== rtl/upq_pkg.sv =====
// Package for the unsorted priority queue: command and status codes and the
// request and response item types. No dependencies.
`default_nettype none

package upq_pkg;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_POP    = 3'd1;
   localparam logic [2:0] CMD_PEEK   = 3'd2;
   localparam logic [2:0] CMD_CHANGE = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] entry_id;
      logic [15:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic [15:0] result_id;
      logic [15:0] result_priority;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/unsorted_priority_queue.sv =====
// Unsorted priority queue with change-key: up to DEPTH (id, priority) entries
// kept in insertion order in one synchronous memory, lower priority first.
// Insert, clear and unused codes, and peek, pop or change on an empty list,
// go straight to a result. Peek and change on N > 0 entries read every held
// entry once through the single read port. A pop reads every entry too and,
// unless it removes the last entry, then moves the K entries behind the
// removed one down by one place.
// A finished result waits in an output register, so the next item is taken
// while it is still unread.
// Depends on upq_pkg, upq_ctrl and upq_mem.
`default_nettype none

module unsorted_priority_queue #(
   parameter int DEPTH     = 64,
   parameter int ID_BITS   = 16,
   parameter int PRIO_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire upq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output upq_pkg::rsp_type       rsp_data
);
   import upq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = ID_BITS + PRIO_BITS;

   logic           done_valid;
   rsp_type        done_data;
   logic           done_take;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [EW-1:0]  mem_wdata;
   logic           mem_re;
   logic [AW-1:0]  mem_raddr;
   logic [EW-1:0]  mem_rdata;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   upq_ctrl #(
      .DEPTH     (DEPTH),
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .done_valid (done_valid),
      .done_data  (done_data),
      .done_take  (done_take),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   upq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (EW),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // The output register takes a new item once it is empty or being drained.
   assign done_take = done_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/upq_mem.sv =====
// Entry memory of the priority queue: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module upq_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/upq_ctrl.sv =====
// Command sequencer of the priority queue: scans the entry memory for the
// minimum or a matching id and compacts the list after a pop. Uses upq_pkg.
`default_nettype none

module upq_ctrl #(
   parameter int DEPTH     = 64,
   parameter int ID_BITS   = 16,
   parameter int PRIO_BITS = 16,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire upq_pkg::req_type              req_data,
   output logic                               done_valid,
   output upq_pkg::rsp_type                   done_data,
   input  wire logic                          done_take,
   output logic                               mem_we,
   output logic [AW-1:0]                      mem_waddr,
   output logic [ID_BITS+PRIO_BITS-1:0]       mem_wdata,
   output logic                               mem_re,
   output logic [AW-1:0]                      mem_raddr,
   input  wire logic [ID_BITS+PRIO_BITS-1:0]  mem_rdata
);
   import upq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [PRIO_BITS-1:0]   prio_ff, prio_in;
   logic [CW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [AW-1:0]          dat_idx_ff, dat_idx_in;
   logic                   found_ff, found_in;
   logic [AW-1:0]          best_idx_ff, best_idx_in;
   logic [ID_BITS-1:0]     best_id_ff, best_id_in;
   logic [PRIO_BITS-1:0]   best_prio_ff, best_prio_in;
   rsp_type                res_ff, res_in;

   logic [ID_BITS-1:0]     rd_id;
   logic [PRIO_BITS-1:0]   rd_prio;
   logic                   take;
   logic                   found_nx;
   logic [AW-1:0]          best_idx_nx;
   logic [ID_BITS-1:0]     best_id_nx;
   logic [PRIO_BITS-1:0]   best_prio_nx;
   logic                   issue;
   logic                   last;
   logic [CW-1:0]          count_m1;

   assign rd_id   = mem_rdata[ID_BITS+PRIO_BITS-1 -: ID_BITS];
   assign rd_prio = mem_rdata[PRIO_BITS-1:0];

   // Strict less-than keeps the entry nearest the front on ties.
   assign take = rd_pend_ff && (!found_ff || rd_prio < best_prio_ff) &&
                 (cmd_ff != CMD_CHANGE || rd_id == id_ff);

   assign found_nx     = found_ff | take;
   assign best_idx_nx  = take ? dat_idx_ff : best_idx_ff;
   assign best_id_nx   = take ? rd_id : best_id_ff;
   assign best_prio_nx = take ? rd_prio : best_prio_ff;

   assign count_m1 = count_ff - CW'(1);
   assign issue    = rd_ptr_ff < count_ff;
   assign last     = rd_pend_ff && (CW'(dat_idx_ff) == count_m1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      prio_in      = prio_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_pend_in   = 1'b0;
      dat_idx_in   = dat_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_id_in   = best_id_ff;
      best_prio_in = best_prio_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = rd_ptr_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               id_in     = ID_BITS'(req_data.entry_id);
               prio_in   = PRIO_BITS'(req_data.entry_priority);
               res_in    = '0;
               rd_ptr_in = '0;
               found_in  = 1'b0;
               state_in  = ST_DONE;
               unique case (req_data.command) inside
                  CMD_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = {ID_BITS'(req_data.entry_id),
                                     PRIO_BITS'(req_data.entry_priority)};
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_CHANGE: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            mem_re       = issue;
            rd_pend_in   = issue;
            dat_idx_in   = rd_ptr_ff[AW-1:0];
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            found_in     = found_nx;
            best_idx_in  = best_idx_nx;
            best_id_in   = best_id_nx;
            best_prio_in = best_prio_nx;
            if (last) begin
               state_in = ST_DONE;
               if (cmd_ff == CMD_CHANGE) begin
                  if (found_nx) begin
                     mem_we    = 1'b1;
                     mem_waddr = best_idx_nx;
                     mem_wdata = {best_id_nx, prio_ff};
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end else begin
                  res_in.result_id       = 16'(best_id_nx);
                  res_in.result_priority = 16'(best_prio_nx);
                  if (cmd_ff == CMD_POP) begin
                     if (CW'(best_idx_nx) == count_m1) begin
                        count_in = count_m1;
                     end else begin
                        // Move every later entry down by one place.
                        rd_ptr_in = CW'(best_idx_nx) + CW'(1);
                        state_in  = ST_SHIFT;
                     end
                  end
               end
            end
         end

         ST_SHIFT: begin
            mem_re     = issue;
            rd_pend_in = issue;
            dat_idx_in = rd_ptr_ff[AW-1:0];
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (rd_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dat_idx_ff - AW'(1);
               mem_wdata = mem_rdata;
            end
            if (last) begin
               count_in = count_m1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      prio_ff      <= prio_in;
      rd_ptr_ff    <= rd_ptr_in;
      dat_idx_ff   <= dat_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
      best_prio_ff <= best_prio_in;
      res_ff       <= res_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);

   always_comb begin
      done_data             = res_ff;
      done_data.entry_count = 7'(count_ff);
   end

endmodule

`default_nettype wire
